// ===== rtl/cpp_token_classifier_top_macros.svh =====
// Assertion macros shared by the checker of the token classifier.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef CPP_TOKEN_CLASSIFIER_TOP_MACROS_SVH
`define CPP_TOKEN_CLASSIFIER_TOP_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define CTC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ctc_pkg.sv =====
// Shared types, character constants and character-class functions of the token classifier.
// Depends on nothing; used by the lexer core, the top level and the checker.
package ctc_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'd0,
		MODE_SLASH  = 4'd1,
		MODE_OP     = 4'd2,
		MODE_LINE   = 4'd3,
		MODE_BLOCK0 = 4'd4,
		MODE_BLOCK  = 4'd5,
		MODE_STRING = 4'd6,
		MODE_NUMBER = 4'd7,
		MODE_IDENT  = 4'd8
	} lex_mode_t;

	localparam logic [2:0] KIND_COMMENT = 3'd0;
	localparam logic [2:0] KIND_STRING  = 3'd1;
	localparam logic [2:0] KIND_NUMBER  = 3'd2;
	localparam logic [2:0] KIND_IDENT   = 3'd3;
	localparam logic [2:0] KIND_OP      = 3'd4;

	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_LF     = 16'h000A;
	localparam logic [15:0] CH_CR     = 16'h000D;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_BANG   = 16'h0021;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_PCT    = 16'h0025;
	localparam logic [15:0] CH_AMP    = 16'h0026;
	localparam logic [15:0] CH_SQUOTE = 16'h0027;
	localparam logic [15:0] CH_STAR   = 16'h002A;
	localparam logic [15:0] CH_PLUS   = 16'h002B;
	localparam logic [15:0] CH_MINUS  = 16'h002D;
	localparam logic [15:0] CH_DOT    = 16'h002E;
	localparam logic [15:0] CH_SLASH  = 16'h002F;
	localparam logic [15:0] CH_ZERO   = 16'h0030;
	localparam logic [15:0] CH_NINE   = 16'h0039;
	localparam logic [15:0] CH_LT     = 16'h003C;
	localparam logic [15:0] CH_EQ     = 16'h003D;
	localparam logic [15:0] CH_GT     = 16'h003E;
	localparam logic [15:0] CH_UP_A   = 16'h0041;
	localparam logic [15:0] CH_UP_F   = 16'h0046;
	localparam logic [15:0] CH_UP_Z   = 16'h005A;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_CARET  = 16'h005E;
	localparam logic [15:0] CH_UNDER  = 16'h005F;
	localparam logic [15:0] CH_LO_A   = 16'h0061;
	localparam logic [15:0] CH_LO_F   = 16'h0066;
	localparam logic [15:0] CH_LO_X   = 16'h0078;
	localparam logic [15:0] CH_LO_Z   = 16'h007A;
	localparam logic [15:0] CH_BAR    = 16'h007C;

	// One result beat as it sits in the output slots.
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] start;
		logic [16:0] length;
		logic        fin;
		logic        too_long;
	} tok_t;

	// Everything one character produces: zero, one or two tokens, in order.
	typedef struct packed {
		logic [1:0] count;
		tok_t       first;
		tok_t       second;
	} lex_out_t;

	function automatic logic is_space(input logic [15:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic is_digit(input logic [15:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_alpha(input logic [15:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic logic is_word(input logic [15:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	function automatic logic is_numchar(input logic [15:0] c);
		return is_digit(c) || c == CH_DOT || c == CH_LO_X ||
			(c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	// True when a followed by b forms one of the two-character operators.
	function automatic logic is_pair(input logic [15:0] a, input logic [15:0] b);
		logic r;
		if (b == CH_EQ) begin
			r = a == CH_EQ || a == CH_BANG || a == CH_LT || a == CH_GT ||
				a == CH_PLUS || a == CH_MINUS || a == CH_STAR || a == CH_SLASH ||
				a == CH_PCT || a == CH_AMP || a == CH_BAR || a == CH_CARET;
		end else begin
			r = a == b && (a == CH_AMP || a == CH_BAR || a == CH_LT || a == CH_GT ||
				a == CH_PLUS || a == CH_MINUS);
		end
		return r;
	endfunction

endpackage

// ===== rtl/ctc_lexer.sv =====
// Lexer core: scan state registers and the per-character token logic.
// Depends on ctc_pkg.
module ctc_lexer
	import ctc_pkg::*;
#(
	parameter int MAX_LEN = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [15:0] char_code,
	input  logic        end_of_text,
	output lex_out_t    result
);

	localparam int P = $clog2(MAX_LEN + 1);
	localparam logic [P-1:0] MAX_P  = P'(MAX_LEN);
	localparam logic [P-1:0] LAST_P = P'(MAX_LEN - 1);

	lex_mode_t   mode_q, mode_d;
	logic [P-1:0] start_q, start_d, cpos_q, cpos_d;
	logic [15:0] quote_q, quote_d, prev_q, prev_d, pend_q, pend_d;
	logic        ovf_q, ovf_d;

	logic         sat, ovf, do_begin, a_v, b_v;
	logic [P-1:0] pos, end_before, end_incl, a_end;
	logic [2:0]   a_kind, b_kind;
	lex_mode_t    mode_m;
	logic [P-1:0] start_m;
	logic [15:0]  quote_m, pend_m;
	tok_t         tok_a, tok_b;

	always_comb begin
		sat        = (cpos_q == MAX_P);
		ovf        = ovf_q | sat;
		pos        = sat ? LAST_P : cpos_q;
		end_before = cpos_q;
		end_incl   = sat ? cpos_q : cpos_q + 1'b1;

		a_v      = 1'b0;
		a_kind   = KIND_OP;
		a_end    = end_before;
		do_begin = 1'b0;
		mode_m   = mode_q;
		start_m  = start_q;
		quote_m  = quote_q;
		pend_m   = pend_q;

		case (mode_q)
			MODE_SLASH: begin
				if (char_code == CH_SLASH) begin
					mode_m = MODE_LINE;
				end else if (char_code == CH_STAR) begin
					mode_m = MODE_BLOCK0;
				end else if (char_code == CH_EQ) begin
					a_v    = 1'b1;
					a_end  = end_incl;
					mode_m = MODE_IDLE;
				end else begin
					a_v      = 1'b1;
					mode_m   = MODE_IDLE;
					do_begin = 1'b1;
				end
			end
			MODE_OP: begin
				a_v    = 1'b1;
				mode_m = MODE_IDLE;
				if (is_pair(pend_q, char_code)) begin
					a_end = end_incl;
				end else begin
					do_begin = 1'b1;
				end
			end
			MODE_LINE: begin
				mode_m = MODE_LINE;
			end
			MODE_BLOCK0: begin
				// The star of the opening pair never closes the comment.
				mode_m = MODE_BLOCK;
			end
			MODE_BLOCK: begin
				if (prev_q == CH_STAR && char_code == CH_SLASH) begin
					a_v    = 1'b1;
					a_kind = KIND_COMMENT;
					a_end  = end_incl;
					mode_m = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (char_code == quote_q && prev_q != CH_BSLASH) begin
					a_v    = 1'b1;
					a_kind = KIND_STRING;
					a_end  = end_incl;
					mode_m = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (!is_numchar(char_code)) begin
					a_v      = 1'b1;
					a_kind   = KIND_NUMBER;
					mode_m   = MODE_IDLE;
					do_begin = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (!is_word(char_code)) begin
					a_v      = 1'b1;
					a_kind   = KIND_IDENT;
					mode_m   = MODE_IDLE;
					do_begin = 1'b1;
				end
			end
			default: begin
				mode_m   = MODE_IDLE;
				do_begin = 1'b1;
			end
		endcase

		// Open a new token on this character unless it is white space.
		if (do_begin && !is_space(char_code)) begin
			start_m = pos;
			if (char_code == CH_SLASH) begin
				mode_m = MODE_SLASH;
			end else if (char_code == CH_DQUOTE || char_code == CH_SQUOTE) begin
				mode_m  = MODE_STRING;
				quote_m = char_code;
			end else if (is_digit(char_code)) begin
				mode_m = MODE_NUMBER;
			end else if (is_alpha(char_code) || char_code == CH_UNDER) begin
				mode_m = MODE_IDENT;
			end else begin
				mode_m = MODE_OP;
				pend_m = char_code;
			end
		end

		// At the end of the text whatever is still open is flushed.
		b_v    = 1'b0;
		b_kind = KIND_OP;
		if (end_of_text) begin
			case (mode_m)
				MODE_SLASH, MODE_OP: begin
					b_v    = 1'b1;
					b_kind = KIND_OP;
				end
				MODE_LINE, MODE_BLOCK0, MODE_BLOCK: begin
					b_v    = 1'b1;
					b_kind = KIND_COMMENT;
				end
				MODE_STRING: begin
					b_v    = 1'b1;
					b_kind = KIND_STRING;
				end
				MODE_NUMBER: begin
					b_v    = 1'b1;
					b_kind = KIND_NUMBER;
				end
				MODE_IDENT: begin
					b_v    = 1'b1;
					b_kind = KIND_IDENT;
				end
				default: begin
					b_v = 1'b0;
				end
			endcase
		end

		tok_a.kind     = a_kind;
		tok_a.start    = 16'(start_q);
		tok_a.length   = 17'(a_end - start_q);
		tok_a.fin      = !b_v;
		tok_a.too_long = ovf;

		tok_b.kind     = b_kind;
		tok_b.start    = 16'(start_m);
		tok_b.length   = 17'(end_incl - start_m);
		tok_b.fin      = 1'b1;
		tok_b.too_long = ovf;

		result.count  = {a_v & b_v, a_v ^ b_v};
		result.first  = a_v ? tok_a : tok_b;
		result.second = tok_b;

		if (end_of_text) begin
			mode_d  = MODE_IDLE;
			start_d = '0;
			cpos_d  = '0;
			quote_d = '0;
			prev_d  = '0;
			pend_d  = '0;
			ovf_d   = 1'b0;
		end else begin
			mode_d  = mode_m;
			start_d = start_m;
			cpos_d  = end_incl;
			quote_d = quote_m;
			prev_d  = char_code;
			pend_d  = pend_m;
			ovf_d   = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			cpos_q  <= '0;
			quote_q <= '0;
			prev_q  <= '0;
			pend_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			cpos_q  <= cpos_d;
			quote_q <= quote_d;
			prev_q  <= prev_d;
			pend_q  <= pend_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

// ===== rtl/cpp_token_classifier_top.sv =====
// Channel   Direction  Handshake            Beat payload
// in        sink       in_valid, in_ready   char_code, end_of_text
// out       source     out_valid, out_ready token_kind, token_start, token_length,
//                                           final_of_run, too_long
//
// One character is taken per cycle while in_ready is high. A beat accepted into the
// input register is lexed when the lexer advances, which loads its tokens into the
// output slots. A character that closes one token and, being the last of the text,
// flushes a second one fills both output slots, so a following character that also
// makes a token waits in the input register until the output slots can take it.
// Reset clears the scan state and both the input and the output slots.
// Ready falls only while the held character makes a token that the output slots
// cannot take: two beats still wait there, or one waits and is not taken now.
//
// Top level of the token classifier; depends on ctc_pkg and ctc_lexer.
module cpp_token_classifier_top
	import ctc_pkg::*;
#(
	parameter int MAX_TEXT_LENGTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_kind,
	output logic [15:0] token_start,
	output logic [16:0] token_length,
	output logic        final_of_run,
	output logic        too_long
);

	// Input register: one character waiting to be lexed.
	logic        valid_s1;
	logic [15:0] char_s1;
	logic        eot_s1;

	// Output slots: slot_a_q is the beat on the port, slot_b_q the one behind it.
	tok_t       slot_a_q, slot_b_q;
	logic [1:0] cnt_q;

	lex_out_t lex;
	logic     load_ok, advance, pop;

	ctc_lexer #(
		.MAX_LEN(MAX_TEXT_LENGTH)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.char_code   (char_s1),
		.end_of_text (eot_s1),
		.result      (lex)
	);

	assign pop     = out_valid && out_ready;
	// The slots can take a fresh pair when empty, or when the last beat leaves now.
	assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	// A character that makes no token never waits for the output side.
	assign advance  = valid_s1 && (lex.count == 2'd0 || load_ok);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance && lex.count != 2'd0) begin
			cnt_q <= lex.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && lex.count != 2'd0) begin
			slot_a_q <= lex.first;
			slot_b_q <= lex.second;
		end else if (pop) begin
			slot_a_q <= slot_b_q;
		end
	end

	assign out_valid    = (cnt_q != 2'd0);
	assign token_kind   = slot_a_q.kind;
	assign token_start  = slot_a_q.start;
	assign token_length = slot_a_q.length;
	assign final_of_run = slot_a_q.fin;
	assign too_long     = slot_a_q.too_long;

endmodule

// ===== rtl/ctc_checker.sv =====
// Port-level checker of the token classifier and its bind to the top level.
// Depends on ctc_pkg and cpp_token_classifier_top_macros.svh.
`include "cpp_token_classifier_top_macros.svh"

module ctc_checker
	import ctc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  token_kind,
	input logic [15:0] token_start,
	input logic [16:0] token_length,
	input logic        final_of_run,
	input logic        too_long
);

	logic [37:0] out_beat;

	assign out_beat = {token_kind, token_start, token_length, final_of_run, too_long};

	// A stalled result beat stays up.
	`CTC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out beat dropped")

	// A stalled result beat keeps its payload.
	`CTC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_beat), "out payload changed")

	// Only the five token kinds are ever shown.
	`CTC_ASSERT(a_kind_range, out_valid |-> token_kind <= KIND_OP, "bad token kind")

	// Every token covers at least one character.
	`CTC_ASSERT(a_len_nonzero, out_valid |-> token_length != 17'd0, "zero length token")

	// Nothing is shown while reset is held.
	`CTC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "out valid in reset")

endmodule

bind cpp_token_classifier_top ctc_checker u_ctc_checker (.*);
